// File: hdl/cma_pkg.sv
// Package for the centerline moving average block: default parameters,
// controller state type, and the command/status structs between control and datapath.
// No dependencies.
`default_nettype none

package cma_pkg;

   localparam int DEF_HALF_WINDOW = 3;
   localparam int DEF_COORD_BITS  = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV_INIT,
      ST_DIV_RUN,
      ST_EMIT,
      ST_DROP,
      ST_PUSH
   } cma_state_type;

   typedef struct packed {
      logic capture;
      logic start;
      logic div_init;
      logic div_step;
      logic emit;
      logic finish;
      logic drop;
      logic push;
   } cma_cmd_type;

   typedef struct packed {
      logic item_last;
      logic has_result;
      logic final_center;
      logic div_done;
      logic out_free;
   } cma_status_type;

endpackage

`default_nettype wire

// File: hdl/centerline_moving_average_top.sv
// Centered moving average of a stream of 2-D centerline points.
//
// Channels: req_ carries one point (x, y, last flag) per transaction; rsp_
// carries one smoothed point per transaction. Both use valid/ready.
// Each point is emitted as the mean of itself and its up to HALF_WINDOW neighbors
// on each side that exist, quotient truncated toward zero. Output lags input by
// HALF_WINDOW points; the point flagged last flushes every point not yet sent
// (up to HALF_WINDOW+1 results) and the final one carries rsp_last_result.
// Results come from the bit-serial restoring divider, one quotient bit per
// cycle, shared by the results of an item (x and y divide side by side).
// Reset clears the sequence count and the running sums; history entries are
// only read once written, so they need no clearing pass.
// A stalled receiver holds the result register; the block goes back to taking
// points while the last result of an item waits, and holds before loading the
// next result until the pending one is taken.
`default_nettype none

module centerline_moving_average_top import cma_pkg::*; #(
   parameter int HALF_WINDOW = DEF_HALF_WINDOW,
   parameter int COORD_BITS  = DEF_COORD_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_point_x,
   input  wire logic signed [COORD_BITS-1:0] req_point_y,
   input  wire logic                         req_last_point,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0]      rsp_smooth_x,
   output logic signed [COORD_BITS-1:0]      rsp_smooth_y,
   output logic                              rsp_last_result
);

   cma_cmd_type    cmd;
   cma_status_type status;

   // sequencer: capture, sum, divide, emit, advance the center, push history
   cma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // history, running sums, divider and result register
   cma_datapath #(
      .HALF_WINDOW (HALF_WINDOW),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_last_point  (req_last_point),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_smooth_x    (rsp_smooth_x),
      .rsp_smooth_y    (rsp_smooth_y),
      .rsp_last_result (rsp_last_result)
   );

endmodule

`default_nettype wire

// File: hdl/cma_ctrl.sv
// Controller state machine of the centerline moving average block.
// Depends on cma_pkg for the state enum and the command/status structs.
`default_nettype none

module cma_ctrl import cma_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire cma_status_type status,
   output cma_cmd_type         cmd
);

   cma_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_START;
         end
         ST_START: begin
            if (status.item_last || status.has_result) state_in = ST_DIV_INIT;
            else state_in = ST_PUSH;
         end
         ST_DIV_INIT: state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (status.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               if (!status.item_last) state_in = ST_PUSH;
               else if (status.final_center) state_in = ST_IDLE;
               else state_in = ST_DROP;
            end
         end
         ST_DROP: state_in = ST_DIV_INIT;
         ST_PUSH: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_START:    cmd.start    = 1'b1;
         ST_DIV_INIT: cmd.div_init = 1'b1;
         ST_DIV_RUN:  cmd.div_step = !status.div_done;
         ST_EMIT: begin
            cmd.emit   = status.out_free;
            cmd.finish = status.out_free && status.item_last && status.final_center;
         end
         ST_DROP: cmd.drop = 1'b1;
         ST_PUSH: cmd.push = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/cma_datapath.sv
// Datapath of the centerline moving average block: point history, window sums,
// bit-serial divider for x and y, and the result register.
// Depends on cma_pkg for the command/status structs and default parameters.
`default_nettype none

module cma_datapath import cma_pkg::*; #(
   parameter int HALF_WINDOW = DEF_HALF_WINDOW,
   parameter int COORD_BITS  = DEF_COORD_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic signed [COORD_BITS-1:0] req_point_x,
   input  wire logic signed [COORD_BITS-1:0] req_point_y,
   input  wire logic                         req_last_point,
   input  wire cma_cmd_type                  cmd,
   output cma_status_type                    status,
   input  wire logic                         rsp_ready,
   output logic                              rsp_valid,
   output logic signed [COORD_BITS-1:0]      rsp_smooth_x,
   output logic signed [COORD_BITS-1:0]      rsp_smooth_y,
   output logic                              rsp_last_result
);

   localparam int HIST_DEPTH    = 2 * HALF_WINDOW;
   localparam int WIN_LEN       = HIST_DEPTH + 1;
   localparam int SUM_BITS      = COORD_BITS + $clog2(WIN_LEN);
   localparam int EXT_BITS      = SUM_BITS - COORD_BITS;
   localparam int CNT_BITS      = $clog2(WIN_LEN + 1);
   localparam int HIST_IDX_BITS = $clog2(HIST_DEPTH);
   localparam int STEP_BITS     = $clog2(SUM_BITS + 1);
   localparam int LANES         = 2;

   localparam logic [CNT_BITS-1:0]  HALF_C    = CNT_BITS'(HALF_WINDOW);
   localparam logic [CNT_BITS-1:0]  DEPTH_C   = CNT_BITS'(HIST_DEPTH);
   localparam logic [STEP_BITS-1:0] STEP_LOAD = STEP_BITS'(SUM_BITS);

   // lane 0 carries x, lane 1 carries y
   logic signed [COORD_BITS-1:0] cur_ff [LANES];
   logic signed [COORD_BITS-1:0] cur_in [LANES];
   logic                         last_ff, last_in;
   logic signed [COORD_BITS-1:0] hist_ff [LANES][HIST_DEPTH];
   logic signed [COORD_BITS-1:0] hist_in [LANES][HIST_DEPTH];
   logic signed [SUM_BITS-1:0]   hist_sum_ff [LANES];
   logic signed [SUM_BITS-1:0]   hist_sum_in [LANES];
   logic [CNT_BITS-1:0]          held_ff, held_in;
   logic signed [SUM_BITS-1:0]   acc_ff [LANES];
   logic signed [SUM_BITS-1:0]   acc_in [LANES];
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]          d_ff, d_in;
   logic                         neg_ff [LANES];
   logic                         neg_in [LANES];
   logic [SUM_BITS-1:0]          mag_ff [LANES];
   logic [SUM_BITS-1:0]          mag_in [LANES];
   logic [CNT_BITS-1:0]          rem_ff [LANES];
   logic [CNT_BITS-1:0]          rem_in [LANES];
   logic [STEP_BITS-1:0]         step_ff, step_in;
   logic signed [COORD_BITS-1:0] res_ff [LANES];
   logic signed [COORD_BITS-1:0] res_in [LANES];
   logic                         res_last_ff, res_last_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [CNT_BITS:0]            trial [LANES];
   logic [CNT_BITS:0]            diff [LANES];
   logic                         ge [LANES];
   logic [SUM_BITS-1:0]          quot [LANES];
   logic signed [SUM_BITS-1:0]   cur_ext [LANES];
   logic signed [SUM_BITS-1:0]   oldest_ext [LANES];
   logic signed [SUM_BITS-1:0]   drop_ext [LANES];
   logic [HIST_IDX_BITS-1:0]     d_idx;
   logic                         drop_hit;
   logic                         final_center;
   logic                         full;

   assign d_idx        = d_ff[HIST_IDX_BITS-1:0];
   assign final_center = (d_ff == HALF_C);
   assign full         = (held_ff == DEPTH_C);
   // the point at window slot d exists once d reaches the oldest held slot
   assign drop_hit     = ({1'b0, d_ff} + {1'b0, held_ff}) >= {1'b0, DEPTH_C};

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         cur_ext[l]    = {{EXT_BITS{cur_ff[l][COORD_BITS-1]}}, cur_ff[l]};
         oldest_ext[l] = {{EXT_BITS{hist_ff[l][0][COORD_BITS-1]}}, hist_ff[l][0]};
         drop_ext[l]   = {{EXT_BITS{hist_ff[l][d_idx][COORD_BITS-1]}}, hist_ff[l][d_idx]};
         trial[l]      = {rem_ff[l], mag_ff[l][SUM_BITS-1]};
         ge[l]         = (trial[l] >= {1'b0, cnt_ff});
         diff[l]       = trial[l] - {1'b0, cnt_ff};
         quot[l]       = neg_ff[l] ? (~mag_ff[l] + SUM_BITS'(1)) : mag_ff[l];
      end
   end

   always_comb begin
      cur_in       = cur_ff;
      last_in      = last_ff;
      hist_in      = hist_ff;
      hist_sum_in  = hist_sum_ff;
      held_in      = held_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      d_in         = d_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.capture) begin
         cur_in[0] = req_point_x;
         cur_in[1] = req_point_y;
         last_in   = req_last_point;
      end

      // full window sum: every held point plus the current one
      if (cmd.start) begin
         for (int l = 0; l < LANES; l++) acc_in[l] = hist_sum_ff[l] + cur_ext[l];
         cnt_in = held_ff + CNT_BITS'(1);
         d_in   = (held_ff < HALF_C) ? (HALF_C - held_ff) : '0;
      end

      if (cmd.div_init) begin
         for (int l = 0; l < LANES; l++) begin
            neg_in[l] = acc_ff[l][SUM_BITS-1];
            mag_in[l] = acc_ff[l][SUM_BITS-1] ? (~acc_ff[l] + SUM_BITS'(1)) : acc_ff[l];
            rem_in[l] = '0;
         end
         step_in = STEP_LOAD;
      end

      // one restoring step per cycle; quotient bits shift into mag
      if (cmd.div_step) begin
         for (int l = 0; l < LANES; l++) begin
            rem_in[l] = ge[l] ? diff[l][CNT_BITS-1:0] : trial[l][CNT_BITS-1:0];
            mag_in[l] = {mag_ff[l][SUM_BITS-2:0], ge[l]};
         end
         step_in = step_ff - STEP_BITS'(1);
      end

      // advance the center: drop the point that falls off the left edge
      if (cmd.drop) begin
         if (drop_hit) begin
            for (int l = 0; l < LANES; l++) acc_in[l] = acc_ff[l] - drop_ext[l];
            cnt_in = cnt_ff - CNT_BITS'(1);
         end
         d_in = d_ff + CNT_BITS'(1);
      end

      if (cmd.push) begin
         for (int l = 0; l < LANES; l++) begin
            for (int k = 0; k < HIST_DEPTH - 1; k++) hist_in[l][k] = hist_ff[l][k + 1];
            hist_in[l][HIST_DEPTH-1] = cur_ff[l];
            hist_sum_in[l] = full ? (hist_sum_ff[l] + cur_ext[l] - oldest_ext[l])
                                  : (hist_sum_ff[l] + cur_ext[l]);
         end
         held_in = full ? DEPTH_C : (held_ff + CNT_BITS'(1));
      end

      if (cmd.finish) begin
         for (int l = 0; l < LANES; l++) hist_sum_in[l] = '0;
         held_in = '0;
      end

      if (cmd.emit) begin
         for (int l = 0; l < LANES; l++) res_in[l] = quot[l][COORD_BITS-1:0];
         res_last_in  = last_ff && final_center;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
         step_ff      <= '0;
         for (int l = 0; l < LANES; l++) hist_sum_ff[l] <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
         step_ff      <= step_in;
         hist_sum_ff  <= hist_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      last_ff     <= last_in;
      hist_ff     <= hist_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      d_ff        <= d_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      res_last_ff <= res_last_in;
   end

   always_comb begin
      status.item_last    = last_ff;
      status.has_result   = (held_ff >= HALF_C);
      status.final_center = final_center;
      status.div_done     = (step_ff == '0);
      status.out_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_smooth_x    = res_ff[0];
   assign rsp_smooth_y    = res_ff[1];
   assign rsp_last_result = res_last_ff;

endmodule

`default_nettype wire

// File: hdl/cma_checker.sv
// Port-level checker for centerline_moving_average_top, with its bind.
// Depends on cma_pkg for the default coordinate width.
`default_nettype none

module cma_checker import cma_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic signed [COORD_BITS-1:0] req_point_x,
   input wire logic signed [COORD_BITS-1:0] req_point_y,
   input wire logic                         req_last_point,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic signed [COORD_BITS-1:0] rsp_smooth_x,
   input wire logic signed [COORD_BITS-1:0] rsp_smooth_y,
   input wire logic                         rsp_last_result
);

   logic [7:0] pending_ff, pending_in;
   logic [2:0] lasts_ff, lasts_in;
   logic       in_txn, out_txn;

   assign in_txn  = req_valid && req_ready;
   assign out_txn = rsp_valid && rsp_ready;

   // every point is emitted once: points in minus results out
   always_comb begin
      pending_in = pending_ff + {7'd0, in_txn} - {7'd0, out_txn};
      lasts_in   = lasts_ff + {2'd0, in_txn && req_last_point}
                 - {2'd0, out_txn && rsp_last_result};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         lasts_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         lasts_ff   <= lasts_in;
      end
   end

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_point_x)
         && $stable(req_point_y) && $stable(req_last_point))
      else $error("request changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_smooth_x)
         && $stable(rsp_smooth_y) && $stable(rsp_last_result))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("result shown with no point outstanding");

   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |-> lasts_ff != 3'd0)
      else $error("final result marked without a last point taken");

endmodule

bind centerline_moving_average_top cma_checker #(.COORD_BITS(COORD_BITS)) u_cma_checker (.*);

`default_nettype wire
